>>> sv/audio_stream_packet_framer_unit_assert.svh
// Assertion helpers shared by the framer RTL.
`ifndef AUDIO_STREAM_PACKET_FRAMER_UNIT_ASSERT_SVH
`define AUDIO_STREAM_PACKET_FRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ASFPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASFPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/asfpf_pkg.sv
package asfpf_pkg;

  // Ring buffer geometry
  localparam int unsigned BUF_DEPTH = 4096;
  localparam int unsigned BUF_AW    = $clog2(BUF_DEPTH);
  localparam int unsigned CNT_W     = BUF_AW + 1;

  // Framing geometry
  localparam int unsigned PKT_BYTES = 1024;
  localparam int unsigned PF_W      = $clog2(PKT_BYTES + 1);
  localparam int unsigned HDR_LEN   = 32;
  localparam int unsigned HP_W      = $clog2(HDR_LEN);
  localparam int unsigned FILL_W    = 13;

  // Operation codes
  localparam logic [2:0] OP_PUSH  = 3'd0;
  localparam logic [2:0] OP_PULL  = 3'd1;
  localparam logic [2:0] OP_START = 3'd2;
  localparam logic [2:0] OP_STOP  = 3'd3;
  localparam logic [2:0] OP_FLUSH = 3'd4;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  data_byte;
    logic [31:0] sample_rate;
    logic [7:0]  channel_count;
    logic [7:0]  sample_bits;
  } item_t;

  typedef struct packed {
    logic              out_valid;
    logic [7:0]        out_byte;
    logic              push_accepted;
    logic              start_rejected;
    logic [FILL_W-1:0] fill_level;
  } result_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    logic [7:0] wdata;
  } ring_ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] count_next;
  } ring_stat_t;

  // Header byte at a given position
  function automatic logic [7:0] header_byte(
    input logic [HP_W-1:0] pos,
    input logic [31:0]     rate,
    input logic [7:0]      chans,
    input logic [7:0]      bits
  );
    case (pos)
      HP_W'(0): header_byte = 8'd1;
      HP_W'(1): header_byte = rate[31:24];
      HP_W'(2): header_byte = rate[23:16];
      HP_W'(3): header_byte = rate[15:8];
      HP_W'(4): header_byte = rate[7:0];
      HP_W'(5): header_byte = chans;
      HP_W'(6): header_byte = bits;
      default:  header_byte = 8'(pos);
    endcase
  endfunction

endpackage

>>> sv/asfpf_ring.sv
module asfpf_ring (
  input  logic                   clk,
  input  logic                   rst,
  input  asfpf_pkg::ring_ctrl_t  ctrl,
  output asfpf_pkg::ring_stat_t  stat,
  output logic [7:0]             rd_data
);
  import asfpf_pkg::*;

  logic [7:0]        mem [BUF_DEPTH];
  logic [BUF_AW-1:0] wr_ptr;
  logic [BUF_AW-1:0] rd_ptr;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;

  // Count after this beat; push and pop never come together
  always_comb begin
    count_next = count;
    if (ctrl.clear) begin
      count_next = '0;
    end else if (ctrl.push) begin
      count_next = count + 1'b1;
    end else if (ctrl.pop) begin
      count_next = count - 1'b1;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (ctrl.clear) begin
        wr_ptr <= '0;
        rd_ptr <= '0;
      end else begin
        if (ctrl.push) wr_ptr <= wr_ptr + 1'b1;
        if (ctrl.pop)  rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  // Storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctrl.push) mem[wr_ptr] <= ctrl.wdata;
    if (ctrl.pop)  rd_data <= mem[rd_ptr];
  end

  assign stat.count      = count;
  assign stat.count_next = count_next;

endmodule

>>> sv/audio_stream_packet_framer_unit.sv
// A result is registered and presented in the cycle after its item is accepted.
// Throughput: one item per cycle while results are taken; the memory has one
// write port and one registered read port, which supplies pulled data bytes.
// Reset: control state, pointers and framing state clear at once; the buffer
// memory is not cleared, its entries are read only after being written.
`include "audio_stream_packet_framer_unit_assert.svh"

module audio_stream_packet_framer_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  asfpf_pkg::item_t  item,
  output logic              result_valid,
  input  logic              result_ready,
  output asfpf_pkg::result_t result
);
  import asfpf_pkg::*;

  // Framing state
  logic [PF_W-1:0] packet_fill,    packet_fill_next;
  logic            header_done,    header_done_next;
  logic            header_active,  header_active_next;
  logic [HP_W-1:0] header_pos,     header_pos_next;
  logic [31:0]     rate_store,     rate_store_next;
  logic [7:0]      chan_store,     chan_store_next;
  logic [7:0]      width_store,    width_store_next;
  logic            running,        running_next;

  // Result stage
  result_t res, res_next, res_load;
  logic    from_mem, from_mem_next;

  ring_ctrl_t ring_ctrl;
  ring_stat_t ring_stat;
  logic [7:0] rd_data;
  logic       accept;

  asfpf_ring u_ring (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ring_ctrl),
    .stat    (ring_stat),
    .rd_data (rd_data)
  );

  assign item_ready = !rst && (!result_valid || result_ready);
  assign accept     = item_valid && item_ready;

  // Decode one beat: framing update, ring control, result fields
  always_comb begin
    packet_fill_next   = packet_fill;
    header_done_next   = header_done;
    header_active_next = header_active;
    header_pos_next    = header_pos;
    rate_store_next    = rate_store;
    chan_store_next    = chan_store;
    width_store_next   = width_store;
    running_next       = running;
    ring_ctrl          = '0;
    ring_ctrl.wdata    = item.data_byte;
    res_next           = '0;
    from_mem_next      = 1'b0;
    if (accept) begin
      case (item.operation)
        OP_PUSH: begin
          if (ring_stat.count < CNT_W'(BUF_DEPTH)) begin
            ring_ctrl.push         = 1'b1;
            res_next.push_accepted = 1'b1;
          end
        end
        OP_PULL: begin
          if (running) begin
            if (!header_done) begin
              res_next.out_valid = 1'b1;
              if (!header_active && packet_fill != PF_W'(PKT_BYTES)
                  && packet_fill != '0) begin
                // pad the open packet with zeros
                packet_fill_next = packet_fill + 1'b1;
              end else begin
                header_active_next = 1'b1;
                res_next.out_byte  = header_byte(header_pos, rate_store,
                                                 chan_store, width_store);
                header_pos_next    = header_pos + 1'b1;
                if (header_pos == HP_W'(HDR_LEN - 1)) begin
                  header_active_next = 1'b0;
                  header_done_next   = 1'b1;
                  packet_fill_next   = '0;
                end
              end
            end else if (packet_fill >= PF_W'(PKT_BYTES)) begin
              // trigger byte after a full packet
              res_next.out_valid = 1'b1;
              packet_fill_next   = '0;
            end else if (ring_stat.count != '0) begin
              res_next.out_valid = 1'b1;
              ring_ctrl.pop      = 1'b1;
              from_mem_next      = 1'b1;
              packet_fill_next   = packet_fill + 1'b1;
            end
          end
        end
        OP_START: begin
          if (item.sample_rate == '0 || item.channel_count == '0
              || item.sample_bits == '0) begin
            res_next.start_rejected = 1'b1;
          end else begin
            rate_store_next    = item.sample_rate;
            chan_store_next    = item.channel_count;
            width_store_next   = item.sample_bits;
            header_done_next   = 1'b0;
            header_active_next = 1'b0;
            header_pos_next    = '0;
            running_next       = 1'b1;
            ring_ctrl.clear    = 1'b1;
          end
        end
        OP_STOP: begin
          running_next = 1'b0;
        end
        OP_FLUSH: begin
          ring_ctrl.clear = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Attach the buffer level after this beat
  always_comb begin
    res_load            = res_next;
    res_load.fill_level = FILL_W'(ring_stat.count_next);
  end

  // Hold framing state
  always_ff @(posedge clk) begin
    if (rst) begin
      packet_fill   <= '0;
      header_done   <= 1'b0;
      header_active <= 1'b0;
      header_pos    <= '0;
      rate_store    <= '0;
      chan_store    <= '0;
      width_store   <= '0;
      running       <= 1'b0;
    end else begin
      packet_fill   <= packet_fill_next;
      header_done   <= header_done_next;
      header_active <= header_active_next;
      header_pos    <= header_pos_next;
      rate_store    <= rate_store_next;
      chan_store    <= chan_store_next;
      width_store   <= width_store_next;
      running       <= running_next;
    end
  end

  // Result register: load on accept, drop on take
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res      <= res_load;
      from_mem <= from_mem_next;
    end
  end

  // Data bytes come from the buffer read register
  always_comb begin
    result = res;
    if (from_mem) result.out_byte = rd_data;
  end

  `ASFPF_ASSERT_NOW(a_idle_byte_zero, result_valid && !result.out_valid,
                    result.out_byte == 8'd0, "byte without out_valid is not zero")
  `ASFPF_ASSERT_NEXT(a_non_pull_silent, accept && item.operation != OP_PULL,
                     result_valid && !result.out_valid, "non-pull beat produced a byte")
  `ASFPF_ASSERT_NOW(a_header_clears_fill, $rose(header_done), packet_fill == '0,
                    "header end left packet fill nonzero")
  `ASFPF_ASSERT_NOW(a_count_bound, 1'b1, ring_stat.count <= CNT_W'(BUF_DEPTH),
                    "buffer count above depth")

endmodule
